>>> rtl/core/lfrc_pkg.sv
`timescale 1ns / 1ps
package lfrc_pkg;

    localparam int CNT_W  = 8;
    localparam int RATE_W = 8;
    localparam int LOSS_W = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    localparam int CONGESTION_LIMIT_DEF = 3;
    localparam int RECOVERY_LIMIT_DEF   = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_TCP_ONLY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAIN_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAIN_MED  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAIN_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SUB_HIGH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SUB_MED   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SUB_LOW   = 3'd7;

    localparam logic [CNT_W-1:0]  FAIL_THR_RST  = 8'd3;
    localparam logic [RATE_W-1:0] MAIN_HIGH_RST = 8'd60;
    localparam logic [RATE_W-1:0] MAIN_MED_RST  = 8'd30;
    localparam logic [RATE_W-1:0] MAIN_LOW_RST  = 8'd15;
    localparam logic [RATE_W-1:0] SUB_HIGH_RST  = 8'd30;
    localparam logic [RATE_W-1:0] SUB_MED_RST   = 8'd15;
    localparam logic [RATE_W-1:0] SUB_LOW_RST   = 8'd10;

    localparam logic [LOSS_W-1:0] LOSS_HIGH   = 10'd100;
    localparam logic [LOSS_W-1:0] LOSS_MOD    = 10'd50;
    localparam logic [LOSS_W-1:0] LOSS_SEVERE = 10'd150;

    localparam logic [3:0] STEP_FAST = 4'd10;
    localparam logic [3:0] STEP_SLOW = 4'd5;

    localparam logic [2:0] MODE_CODE_NORMAL    = 3'd0;
    localparam logic [2:0] MODE_CODE_OFFLOAD   = 3'd1;
    localparam logic [2:0] MODE_CODE_REDUCED   = 3'd2;
    localparam logic [2:0] MODE_CODE_USB_FAIL  = 3'd3;
    localparam logic [2:0] MODE_CODE_WIFI_FAIL = 3'd4;
    localparam logic [2:0] MODE_CODE_BOTH      = 3'd5;

    typedef enum logic [5:0] {
        MS_NORMAL    = 6'b000001,
        MS_OFFLOAD   = 6'b000010,
        MS_REDUCED   = 6'b000100,
        MS_USB_FAIL  = 6'b001000,
        MS_WIFI_FAIL = 6'b010000,
        MS_BOTH      = 6'b100000
    } t_mode;

    typedef struct packed {
        logic              wifi_only;
        logic [CNT_W-1:0]  fail_thr;
        logic [RATE_W-1:0] main_high;
        logic [RATE_W-1:0] main_med;
        logic [RATE_W-1:0] main_low;
        logic [RATE_W-1:0] sub_high;
        logic [RATE_W-1:0] sub_med;
        logic [RATE_W-1:0] sub_low;
    } t_cfg;

    typedef struct packed {
        logic              usb_alive;
        logic              usb_busy;
        logic              wifi_alive;
        logic [LOSS_W-1:0] loss;
    } t_sample;

    typedef struct packed {
        logic [CNT_W-1:0] usb_cong;
        logic [CNT_W-1:0] usb_fail;
        logic [CNT_W-1:0] wifi_fail;
        logic [CNT_W-1:0] recovery;
    } t_counts;

    typedef struct packed {
        logic usb_lost;
        logic wifi_lost;
        logic usb_overload;
    } t_health;

    typedef struct packed {
        t_mode             mode;
        logic              video;
        logic              control;
        logic [RATE_W-1:0] main_rate;
        logic [RATE_W-1:0] sub_rate;
    } t_route;

    function automatic logic [CNT_W-1:0] f_sat_inc(input logic [CNT_W-1:0] c);
        return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

    function automatic logic [RATE_W-1:0] f_ramp_up(input logic [RATE_W-1:0] cur,
                                                   input logic [RATE_W-1:0] tgt,
                                                   input logic [3:0] step);
        logic [RATE_W:0] sum;
        sum = {1'b0, cur} + {{(RATE_W-3){1'b0}}, step};
        return (sum < {1'b0, tgt}) ? sum[RATE_W-1:0] : tgt;
    endfunction

    function automatic logic [RATE_W-1:0] f_ramp_down(input logic [RATE_W-1:0] cur,
                                                     input logic [RATE_W-1:0] tgt,
                                                     input logic [3:0] step);
        logic [RATE_W:0] dif;
        dif = {1'b0, cur} - {{(RATE_W-3){1'b0}}, step};
        if (dif[RATE_W]) begin
            return tgt;
        end
        return (dif[RATE_W-1:0] > tgt) ? dif[RATE_W-1:0] : tgt;
    endfunction

    function automatic logic [2:0] f_mode_code(input t_mode m);
        logic [2:0] c;
        case (m)
            MS_NORMAL:    c = MODE_CODE_NORMAL;
            MS_OFFLOAD:   c = MODE_CODE_OFFLOAD;
            MS_REDUCED:   c = MODE_CODE_REDUCED;
            MS_USB_FAIL:  c = MODE_CODE_USB_FAIL;
            MS_WIFI_FAIL: c = MODE_CODE_WIFI_FAIL;
            MS_BOTH:      c = MODE_CODE_BOTH;
            default:      c = MODE_CODE_NORMAL;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/core/lfrc_health.sv
`timescale 1ns / 1ps
module lfrc_health #(
    parameter int CONGESTION_LIMIT = lfrc_pkg::CONGESTION_LIMIT_DEF
) (
    input  lfrc_pkg::t_cfg    i_cfg,
    input  lfrc_pkg::t_sample i_sample,
    input  lfrc_pkg::t_counts i_counts,
    output lfrc_pkg::t_counts o_counts,
    output lfrc_pkg::t_health o_health
);
    import lfrc_pkg::*;

    localparam logic [CNT_W-1:0] CongLimit = CNT_W'(CONGESTION_LIMIT);

    t_counts c;

    always_comb begin
        c = i_counts;
        if (!i_cfg.wifi_only) begin
            if (i_sample.usb_busy) begin
                c.usb_cong = f_sat_inc(i_counts.usb_cong);
                c.recovery = '0;
            end else begin
                c.usb_cong = '0;
            end
            if (!i_sample.usb_alive) begin
                c.usb_fail = f_sat_inc(i_counts.usb_fail);
                c.recovery = '0;
            end else begin
                c.usb_fail = '0;
            end
        end
        if (!i_sample.wifi_alive) begin
            c.wifi_fail = f_sat_inc(i_counts.wifi_fail);
            c.recovery  = '0;
        end else begin
            c.wifi_fail = '0;
        end
    end

    assign o_counts = c;
    assign o_health.wifi_lost    = (c.wifi_fail >= i_cfg.fail_thr);
    assign o_health.usb_lost     = (c.usb_fail >= i_cfg.fail_thr);
    assign o_health.usb_overload = (c.usb_cong >= CongLimit);

endmodule

>>> rtl/core/lfrc_decide.sv
`timescale 1ns / 1ps
module lfrc_decide #(
    parameter int RECOVERY_LIMIT = lfrc_pkg::RECOVERY_LIMIT_DEF
) (
    input  lfrc_pkg::t_cfg                   i_cfg,
    input  lfrc_pkg::t_sample                i_sample,
    input  lfrc_pkg::t_health                i_health,
    input  logic [lfrc_pkg::CNT_W-1:0]       i_recovery,
    input  lfrc_pkg::t_route                 i_route,
    output lfrc_pkg::t_route                 o_route,
    output logic [lfrc_pkg::CNT_W-1:0]       o_recovery
);
    import lfrc_pkg::*;

    localparam logic [CNT_W-1:0] RecLimit = CNT_W'(RECOVERY_LIMIT);

    t_route           r;
    logic [CNT_W-1:0] rc;
    logic [CNT_W-1:0] rc_inc;
    logic             loss_high;
    logic             loss_mod;
    logic             loss_clean;
    logic             loss_severe;

    assign rc_inc      = f_sat_inc(i_recovery);
    assign loss_high   = (i_sample.loss > LOSS_HIGH);
    assign loss_mod    = (i_sample.loss > LOSS_MOD);
    assign loss_clean  = (i_sample.loss < LOSS_MOD);
    assign loss_severe = (i_sample.loss > LOSS_SEVERE);

    always_comb begin
        r  = i_route;
        rc = i_recovery;
        if (i_cfg.wifi_only) begin
            if (i_health.wifi_lost) begin
                r.main_rate = i_cfg.main_low;
                r.sub_rate  = i_cfg.sub_low;
                r.mode      = MS_BOTH;
            end else if (loss_high) begin
                r.main_rate = f_ramp_down(i_route.main_rate, i_cfg.main_med, STEP_FAST);
                r.sub_rate  = f_ramp_down(i_route.sub_rate, i_cfg.sub_low, STEP_SLOW);
            end else if (loss_mod) begin
                r.main_rate = f_ramp_down(i_route.main_rate, i_cfg.main_med, STEP_SLOW);
                r.sub_rate  = f_ramp_down(i_route.sub_rate, i_cfg.sub_med, STEP_SLOW);
            end else begin
                r.main_rate = f_ramp_up(i_route.main_rate, i_cfg.main_high, STEP_SLOW);
                r.sub_rate  = f_ramp_up(i_route.sub_rate, i_cfg.sub_high, STEP_SLOW);
                if (i_route.mode != MS_NORMAL) begin
                    rc = rc_inc;
                    if (rc_inc >= RecLimit) begin
                        r.mode = MS_NORMAL;
                        rc     = '0;
                    end
                end
            end
            r.video   = 1'b1;
            r.control = 1'b1;
        end else begin
            case (i_route.mode)
                MS_NORMAL: begin
                    if (i_health.usb_lost) begin
                        r.mode      = MS_USB_FAIL;
                        r.video     = 1'b1;
                        r.control   = 1'b1;
                        r.main_rate = i_cfg.main_med;
                        r.sub_rate  = i_cfg.sub_med;
                    end else if (i_health.wifi_lost) begin
                        r.mode      = MS_WIFI_FAIL;
                        r.video     = 1'b0;
                        r.control   = 1'b0;
                        r.main_rate = i_cfg.main_low;
                        r.sub_rate  = i_cfg.sub_low;
                    end else if (i_health.usb_overload) begin
                        r.mode    = MS_OFFLOAD;
                        r.video   = 1'b1;
                        r.control = 1'b0;
                    end
                end
                MS_OFFLOAD: begin
                    if (i_health.usb_lost) begin
                        r.mode    = MS_USB_FAIL;
                        r.control = 1'b1;
                    end else if (i_health.wifi_lost) begin
                        r.mode      = MS_WIFI_FAIL;
                        r.video     = 1'b0;
                        r.control   = 1'b0;
                        r.main_rate = i_cfg.main_low;
                        r.sub_rate  = i_cfg.sub_low;
                    end else if (loss_high) begin
                        r.mode      = MS_REDUCED;
                        r.main_rate = f_ramp_down(i_route.main_rate, i_cfg.main_low,
                                                  STEP_SLOW);
                        r.sub_rate  = f_ramp_down(i_route.sub_rate, i_cfg.sub_low,
                                                  STEP_SLOW);
                    end else if (!i_sample.usb_busy) begin
                        rc = rc_inc;
                        if (rc_inc >= RecLimit) begin
                            r.mode  = MS_NORMAL;
                            r.video = 1'b0;
                            rc      = '0;
                        end
                    end
                end
                MS_REDUCED: begin
                    if (!i_sample.usb_busy && loss_clean && !i_health.wifi_lost) begin
                        rc = rc_inc;
                        if (rc_inc >= RecLimit) begin
                            r.main_rate = f_ramp_up(i_route.main_rate, i_cfg.main_high,
                                                    STEP_SLOW);
                            r.sub_rate  = f_ramp_up(i_route.sub_rate, i_cfg.sub_high,
                                                    STEP_SLOW);
                            if (r.main_rate >= i_cfg.main_high) begin
                                r.mode = MS_OFFLOAD;
                            end
                            rc = '0;
                        end
                    end else begin
                        rc = '0;
                        if (loss_severe) begin
                            r.main_rate = f_ramp_down(i_route.main_rate, i_cfg.main_low,
                                                      STEP_SLOW);
                            r.sub_rate  = f_ramp_down(i_route.sub_rate, i_cfg.sub_low,
                                                      STEP_SLOW);
                        end
                        if (i_health.wifi_lost) begin
                            r.mode      = MS_WIFI_FAIL;
                            r.video     = 1'b0;
                            r.control   = 1'b0;
                            r.main_rate = i_cfg.main_low;
                            r.sub_rate  = i_cfg.sub_low;
                        end
                        if (i_health.usb_lost) begin
                            r.mode      = MS_USB_FAIL;
                            r.video     = 1'b1;
                            r.control   = 1'b1;
                            r.main_rate = i_cfg.main_med;
                            r.sub_rate  = i_cfg.sub_med;
                        end
                    end
                end
                MS_USB_FAIL: begin
                    if (i_sample.usb_alive) begin
                        rc = rc_inc;
                        if (rc_inc >= RecLimit) begin
                            r.mode    = MS_OFFLOAD;
                            r.control = 1'b0;
                            rc        = '0;
                        end
                    end else begin
                        rc = '0;
                    end
                end
                MS_WIFI_FAIL: begin
                    if (i_sample.wifi_alive) begin
                        rc = rc_inc;
                        if (rc_inc >= RecLimit) begin
                            r.main_rate = f_ramp_up(i_route.main_rate, i_cfg.main_high,
                                                    STEP_SLOW);
                            r.sub_rate  = f_ramp_up(i_route.sub_rate, i_cfg.sub_high,
                                                    STEP_SLOW);
                            if (r.main_rate >= i_cfg.main_high) begin
                                r.mode = MS_NORMAL;
                            end
                            rc = '0;
                        end
                    end else begin
                        rc = '0;
                    end
                end
                MS_BOTH: begin
                    if (i_sample.usb_alive && !i_sample.usb_busy) begin
                        r.mode    = MS_WIFI_FAIL;
                        r.video   = 1'b0;
                        r.control = 1'b0;
                    end else if (i_sample.wifi_alive) begin
                        r.mode    = MS_USB_FAIL;
                        r.video   = 1'b1;
                        r.control = 1'b1;
                    end
                end
                default: begin
                    r = i_route;
                end
            endcase
        end
    end

    assign o_route    = r;
    assign o_recovery = rc;

endmodule

>>> rtl/core/link_failover_rate_controller.sv
`timescale 1ns / 1ps
// Link failover and frame-rate controller.
// Each transaction on the slave stream carries one health sample of the USB and
// WiFi links. Each transaction on the master stream carries the resulting route
// mode, the video and control routes, the main and sub frame rates and a flag
// that is set when the video route or either rate changed.
// The configuration port writes the TCP-only switch, the failure threshold and
// the six rate levels; the user must write it only while no transaction is in
// flight, and the block itself does not enforce this. A sample is held in an
// input register and processed from there into the output register.
// One sample per cycle is sustained while the receiver does not stall; the
// counters and the route state are updated together as each sample advances.
// When the receiver stalls, the result waits in the output register and one
// more sample can be held in the input register before tready drops.
// Synchronous reset returns the mode to normal, both routes to USB, the rates
// to the default high levels, all counters to zero and the configuration
// registers to their default values; no result is pending after reset.
module link_failover_rate_controller #(
    parameter int CONGESTION_LIMIT = lfrc_pkg::CONGESTION_LIMIT_DEF,
    parameter int RECOVERY_LIMIT   = lfrc_pkg::RECOVERY_LIMIT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lfrc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lfrc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // usb_alive[0], usb_busy[1], wifi_alive[2], wifi_loss_permille[12:3]
    input  logic [lfrc_pkg::S_TDATA_W-1:0]      i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // route_mode[2:0], video_on_wifi[3], control_on_wifi[4], main_rate[12:5],
    // sub_rate[20:13], decision_changed[21]
    output logic [lfrc_pkg::M_TDATA_W-1:0]      o_m_axis_tdata
);
    import lfrc_pkg::*;

    t_cfg             r_cfg;
    t_sample          r_in;
    logic             r_in_valid;
    t_counts          r_counts;
    t_route           r_route;
    logic             r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    t_counts          n_counts;
    t_health          health;
    t_route           n_route;
    logic [CNT_W-1:0] n_recovery;
    logic             advance;
    logic             in_accept;
    logic             changed;
    logic [M_TDATA_W-1:0] n_out_data;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    lfrc_health #(
        .CONGESTION_LIMIT (CONGESTION_LIMIT)
    ) u_health (
        .i_cfg    (r_cfg),
        .i_sample (r_in),
        .i_counts (r_counts),
        .o_counts (n_counts),
        .o_health (health)
    );

    lfrc_decide #(
        .RECOVERY_LIMIT (RECOVERY_LIMIT)
    ) u_decide (
        .i_cfg      (r_cfg),
        .i_sample   (r_in),
        .i_health   (health),
        .i_recovery (n_counts.recovery),
        .i_route    (r_route),
        .o_route    (n_route),
        .o_recovery (n_recovery)
    );

    assign changed = (n_route.video != r_route.video) ||
                     (n_route.main_rate != r_route.main_rate) ||
                     (n_route.sub_rate != r_route.sub_rate);

    assign n_out_data = {2'b00, changed, n_route.sub_rate, n_route.main_rate,
                         n_route.control, n_route.video, f_mode_code(n_route.mode)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wifi_only <= 1'b0;
            r_cfg.fail_thr  <= FAIL_THR_RST;
            r_cfg.main_high <= MAIN_HIGH_RST;
            r_cfg.main_med  <= MAIN_MED_RST;
            r_cfg.main_low  <= MAIN_LOW_RST;
            r_cfg.sub_high  <= SUB_HIGH_RST;
            r_cfg.sub_med   <= SUB_MED_RST;
            r_cfg.sub_low   <= SUB_LOW_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TCP_ONLY:  r_cfg.wifi_only <= i_cfg_wdata[0];
                CFG_FAIL_THR:  r_cfg.fail_thr  <= i_cfg_wdata;
                CFG_MAIN_HIGH: r_cfg.main_high <= i_cfg_wdata;
                CFG_MAIN_MED:  r_cfg.main_med  <= i_cfg_wdata;
                CFG_MAIN_LOW:  r_cfg.main_low  <= i_cfg_wdata;
                CFG_SUB_HIGH:  r_cfg.sub_high  <= i_cfg_wdata;
                CFG_SUB_MED:   r_cfg.sub_med   <= i_cfg_wdata;
                CFG_SUB_LOW:   r_cfg.sub_low   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.usb_alive  <= i_s_axis_tdata[0];
            r_in.usb_busy   <= i_s_axis_tdata[1];
            r_in.wifi_alive <= i_s_axis_tdata[2];
            r_in.loss       <= i_s_axis_tdata[12:3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counts          <= '0;
            r_route.mode      <= MS_NORMAL;
            r_route.video     <= 1'b0;
            r_route.control   <= 1'b0;
            r_route.main_rate <= MAIN_HIGH_RST;
            r_route.sub_rate  <= SUB_HIGH_RST;
            r_out_valid       <= 1'b0;
        end else if (advance) begin
            r_counts.usb_cong  <= n_counts.usb_cong;
            r_counts.usb_fail  <= n_counts.usb_fail;
            r_counts.wifi_fail <= n_counts.wifi_fail;
            r_counts.recovery  <= n_recovery;
            r_route            <= n_route;
            r_out_valid        <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule
